@@ design/ppmd_pkg.sv @@
// Shared constants, register codes and types of the PPM pulse train decoder.
`default_nettype none

package ppmd_pkg;

  // Field widths
  localparam int TIME_W     = 16;
  localparam int SLOT_W     = 5;
  localparam int CH_W       = 3;
  localparam int CH_COUNT   = 8;
  localparam int POS_W      = 16;
  localparam int TRAIN_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Parameter defaults
  localparam int MAX_SLOTS_DEF    = 16;
  localparam int NUM_CHANNELS_DEF = 8;

  // Decoding constants
  localparam logic [TIME_W-1:0] MIN_INTERVAL = 16'd450;
  localparam logic [POS_W-1:0]  FULL_SCALE   = 16'hFFFF;
  localparam int                QUO_STEPS    = 16;

  // Register reset values
  localparam logic [15:0] SEPARATION_RST = 16'd65535;
  localparam logic [4:0]  SLOTS_RST      = 5'd16;
  localparam logic        PAG_RST        = 1'b0;
  localparam logic [15:0] MIN_WIDTH_RST  = 16'd500;
  localparam logic [15:0] MAX_WIDTH_RST  = 16'd1500;
  localparam logic [7:0]  ENABLE_RST     = 8'd0;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEPARATION      = 3'd0,
    CFG_SLOTS_EXPECTED  = 3'd1,
    CFG_PULSE_AFTER_GAP = 3'd2,
    CFG_MIN_WIDTH       = 3'd3,
    CFG_MAX_WIDTH       = 3'd4,
    CFG_CHANNEL_ENABLE  = 3'd5
  } cfg_idx_t;

  // Register file contents
  typedef struct packed {
    logic [15:0]         train_separation;
    logic [4:0]          slots_expected;
    logic                pulse_after_gap;
    logic [15:0]         min_width;
    logic [15:0]         max_width;
    logic [CH_COUNT-1:0] channel_enable;
  } cfg_t;

endpackage

`default_nettype wire

@@ design/ppmd_if.sv @@
// Valid/ready channel interfaces for capture items and channel result items.
`default_nettype none

interface ppmd_in_if;
  logic                          valid;
  logic                          ready;
  logic [ppmd_pkg::TIME_W-1:0]   capture_time;

  modport source (output valid, output capture_time, input ready);
  modport sink   (input valid, input capture_time, output ready);
endinterface

interface ppmd_out_if;
  logic                          valid;
  logic                          ready;
  logic [ppmd_pkg::CH_W-1:0]     channel;
  logic [ppmd_pkg::POS_W-1:0]    position;
  logic [ppmd_pkg::TRAIN_W-1:0]  trains_seen;
  logic                          last;

  modport source (output valid, output channel, output position, output trains_seen,
                  output last, input ready);
  modport sink   (input valid, input channel, input position, input trains_seen,
                  input last, output ready);
endinterface

`default_nettype wire

@@ design/ppmd_cfg_regs.sv @@
// Configuration register file of the PPM pulse train decoder.
`default_nettype none

module ppmd_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [ppmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ppmd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output ppmd_pkg::cfg_t                         cfg
);
  import ppmd_pkg::*;

  cfg_t cfg_r;

  // Write the addressed register; ignore indexes past the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.train_separation <= SEPARATION_RST;
      cfg_r.slots_expected   <= SLOTS_RST;
      cfg_r.pulse_after_gap  <= PAG_RST;
      cfg_r.min_width        <= MIN_WIDTH_RST;
      cfg_r.max_width        <= MAX_WIDTH_RST;
      cfg_r.channel_enable   <= ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SEPARATION:      cfg_r.train_separation <= cfg_wdata;
        CFG_SLOTS_EXPECTED:  cfg_r.slots_expected   <= cfg_wdata[4:0];
        CFG_PULSE_AFTER_GAP: cfg_r.pulse_after_gap  <= cfg_wdata[0];
        CFG_MIN_WIDTH:       cfg_r.min_width        <= cfg_wdata;
        CFG_MAX_WIDTH:       cfg_r.max_width        <= cfg_wdata;
        CFG_CHANNEL_ENABLE:  cfg_r.channel_enable   <= cfg_wdata[CH_COUNT-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ design/ppmd_scaler.sv @@
// Window clamp and bit-serial divider that scales one interval to 0..65535.
`default_nettype none

module ppmd_scaler (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [ppmd_pkg::TIME_W-1:0]    width,
  input  wire logic [ppmd_pkg::TIME_W-1:0]    min_width,
  input  wire logic [ppmd_pkg::TIME_W-1:0]    max_width,
  output logic                                done,
  output logic [ppmd_pkg::POS_W-1:0]          position
);
  import ppmd_pkg::*;

  localparam int STEP_W = $clog2(QUO_STEPS + 1);

  typedef enum logic {SC_IDLE, SC_RUN} sc_state_t;

  sc_state_t           state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [TIME_W-1:0]   rem_r, rem_nxt;
  logic [TIME_W-1:0]   span_r, span_nxt;
  logic [POS_W-1:0]    quo_r, quo_nxt;
  logic                done_r, done_nxt;
  logic [TIME_W-1:0]   offset;
  logic [TIME_W-1:0]   span_in;
  logic [TIME_W:0]     rem_dbl;
  logic                fits;

  assign offset  = width - min_width;
  assign span_in = max_width - min_width;
  // One restoring step: double the remainder, subtract the span when it fits
  assign rem_dbl = {rem_r, 1'b0};
  assign fits    = rem_dbl >= {1'b0, span_r};

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    span_nxt  = span_r;
    quo_nxt   = quo_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      SC_IDLE: begin
        if (start) begin
          // Clamp outside the window and at its top, else divide
          if (width < min_width) begin
            quo_nxt  = '0;
            done_nxt = 1'b1;
          end else if (width > max_width || offset == span_in) begin
            quo_nxt  = FULL_SCALE;
            done_nxt = 1'b1;
          end else begin
            rem_nxt   = offset;
            span_nxt  = span_in;
            quo_nxt   = '0;
            step_nxt  = STEP_W'(QUO_STEPS);
            state_nxt = SC_RUN;
          end
        end
      end
      SC_RUN: begin
        // Shift one quotient bit in per cycle
        rem_nxt  = fits ? TIME_W'(rem_dbl - {1'b0, span_r}) : rem_dbl[TIME_W-1:0];
        quo_nxt  = {quo_r[POS_W-2:0], fits};
        step_nxt = step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          done_nxt  = 1'b1;
          state_nxt = SC_IDLE;
        end
      end
      default: state_nxt = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      done_r  <= done_nxt;
    end
    rem_r  <= rem_nxt;
    span_r <= span_nxt;
    quo_r  <= quo_nxt;
  end

  assign done     = done_r;
  assign position = quo_r;

endmodule

`default_nettype wire

@@ design/ppm_pulse_train_decoder.sv @@
// Top level of the PPM pulse train decoder: slot tracking, interval store, channel walk.
// Input flow: a capture that does not close a train is taken while the sequencer is idle;
// one that closes a train blocks the input for the channel walk, which skips channels not
// due and reads, scales (16-step divider) and loads each due result, plus any output stall.
// The result register lets the next item in while the final result waits to be taken.
// Reset (synchronous, active low) clears slot, trains, last capture and registers, not the store.
`default_nettype none

module ppm_pulse_train_decoder #(
  parameter int MAX_SLOTS    = ppmd_pkg::MAX_SLOTS_DEF,
  parameter int NUM_CHANNELS = ppmd_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  ppmd_in_if.sink                                in_if,
  ppmd_out_if.source                             out_if,
  input  wire logic                              cfg_we,
  input  wire logic [ppmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ppmd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ppmd_pkg::*;

  localparam int ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int EXP_W  = SLOT_W + 1;
  localparam int NCH    = (NUM_CHANNELS < CH_COUNT) ? NUM_CHANNELS : CH_COUNT;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_READ, S_SCALE, S_OUT} state_t;

  cfg_t                 cfg;
  state_t               state_r, state_nxt;
  logic [TIME_W-1:0]    prev_r, prev_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [TRAIN_W-1:0]   train_r, train_nxt;
  logic [CH_COUNT-1:0]  rem_r, rem_nxt;
  logic [CH_W-1:0]      ch_r, ch_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]      out_chan_r, out_chan_nxt;
  logic [POS_W-1:0]     out_pos_r, out_pos_nxt;
  logic [TRAIN_W-1:0]   out_trains_r, out_trains_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [TIME_W-1:0]    store_mem [MAX_SLOTS];
  logic [TIME_W-1:0]    rd_q_r;

  logic                 accept;
  logic [TIME_W-1:0]    diff;
  logic [TIME_W-1:0]    width;
  logic                 short_gap;
  logic [SLOT_W-1:0]    slot_eff;
  logic [SLOT_W-1:0]    slot_inc;
  logic [EXP_W-1:0]     expected;
  logic                 train_done;
  logic                 wr_en;
  logic [CH_COUNT-1:0]  emit_mask;
  logic [CH_COUNT-1:0]  ch_onehot;
  logic [SLOT_W-1:0]    rd_slot;
  logic                 scl_start;
  logic                 scl_done;
  logic [POS_W-1:0]     scl_pos;

  ppmd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ppmd_scaler u_scaler (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scl_start),
    .width     (rd_q_r),
    .min_width (cfg.min_width),
    .max_width (cfg.max_width),
    .done      (scl_done),
    .position  (scl_pos)
  );

  // Interval since the last capture, times four, modulo 2^16
  assign accept    = in_if.valid && in_if.ready;
  assign diff      = in_if.capture_time - prev_r;
  assign width     = {diff[TIME_W-3:0], 2'b00};
  assign short_gap = width < MIN_INTERVAL;

  // Slot bookkeeping: restart after a long gap, clamp the train length
  assign slot_eff   = (width > cfg.train_separation) ? '0 : slot_r;
  assign slot_inc   = slot_eff + 1'b1;
  assign expected   = ({1'b0, cfg.slots_expected} > EXP_W'(MAX_SLOTS)) ?
                      EXP_W'(MAX_SLOTS) : {1'b0, cfg.slots_expected};
  assign train_done = {1'b0, slot_inc} >= expected;
  assign wr_en      = accept && !short_gap && ({1'b0, slot_eff} < EXP_W'(MAX_SLOTS));

  // Channels that will report at the end of this train
  always_comb begin
    logic [SLOT_W-1:0] slot_c;
    for (int c = 0; c < CH_COUNT; c++) begin
      slot_c       = {1'b0, CH_W'(c), cfg.pulse_after_gap};
      emit_mask[c] = (c < NCH) && cfg.channel_enable[c] &&
                     (cfg.pulse_after_gap || (c != 0)) &&
                     ({1'b0, slot_c} < expected);
    end
  end

  assign ch_onehot = CH_COUNT'(1) << ch_r;
  assign rd_slot   = {1'b0, ch_r, cfg.pulse_after_gap};
  assign scl_start = (state_r == S_READ);

  // Interval store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[slot_eff[ADDR_W-1:0]] <= width;
    end
    rd_q_r <= store_mem[rd_slot[ADDR_W-1:0]];
  end

  assign in_if.ready = (state_r == S_IDLE);

  // Sequencer: take captures, then walk the channels of a finished train
  always_comb begin
    state_nxt      = state_r;
    prev_nxt       = prev_r;
    slot_nxt       = slot_r;
    train_nxt      = train_r;
    rem_nxt        = rem_r;
    ch_nxt         = ch_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_chan_nxt   = out_chan_r;
    out_pos_nxt    = out_pos_r;
    out_trains_nxt = out_trains_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          prev_nxt = in_if.capture_time;
          if (!short_gap) begin
            if (train_done) begin
              train_nxt = train_r + 1'b1;
              slot_nxt  = '0;
              rem_nxt   = emit_mask;
              ch_nxt    = '0;
              state_nxt = S_SCAN;
            end else begin
              slot_nxt = slot_inc;
            end
          end
        end
      end
      S_SCAN: begin
        if (rem_r == '0) begin
          state_nxt = S_IDLE;
        end else if (rem_r[ch_r]) begin
          state_nxt = S_READ;
        end else begin
          ch_nxt = ch_r + 1'b1;
        end
      end
      S_READ: begin
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        if (scl_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Load the result register once it is free
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_chan_nxt   = ch_r;
          out_pos_nxt    = scl_pos;
          out_trains_nxt = train_r;
          out_last_nxt   = (rem_r & ~ch_onehot) == '0;
          rem_nxt        = rem_r & ~ch_onehot;
          ch_nxt         = ch_r + 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      slot_r      <= '0;
      train_r     <= '0;
      rem_r       <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      slot_r      <= slot_nxt;
      train_r     <= train_nxt;
      rem_r       <= rem_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_chan_r   <= out_chan_nxt;
    out_pos_r    <= out_pos_nxt;
    out_trains_r <= out_trains_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.channel     = out_chan_r;
  assign out_if.position    = out_pos_r;
  assign out_if.trains_seen = out_trains_r;
  assign out_if.last        = out_last_r;

  // Divider finishes only while the sequencer waits for it
  a_done_in_scale: assert property (@(posedge clk) disable iff (!rst_n)
    scl_done |-> state_r == S_SCALE)
    else $error("scaler done outside of scale wait");

  // No channel left pending once back to taking captures
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> rem_r == '0)
    else $error("pending channels while idle");

  // A result is only issued for a pending channel
  a_out_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> rem_r[ch_r])
    else $error("result stage on a channel that is not pending");

endmodule

`default_nettype wire

@@ tb/tb_ppm_pulse_train_decoder.sv @@
// Self-checking testbench of the PPM pulse train decoder: random PPM trains against a predictor.
`timescale 1ns / 100ps

module tb_ppm_pulse_train_decoder;
  import ppmd_pkg::*;

  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD     = 600;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int WIDTH_TOP     = 65532;
  localparam int SHORT_TOP     = 448;
  localparam int KEPT_FLOOR    = 452;

  typedef struct {
    logic [CH_W-1:0]    channel;
    logic [POS_W-1:0]   position;
    logic [TRAIN_W-1:0] trains_seen;
    logic               last;
  } chan_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ppmd_in_if  in_ch ();
  ppmd_out_if out_ch ();

  ppm_pulse_train_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register mirror
  logic [15:0] sep_limit;
  logic [4:0]  slot_count;
  logic        odd_slots;
  logic [15:0] min_w;
  logic [15:0] max_w;
  logic [7:0]  ch_enable;

  // Decoder state mirror
  logic [15:0]  prev_capture;
  logic [15:0]  interval_mem [MAX_SLOTS_DEF];
  logic [4:0]   slot_idx;
  logic [15:0]  train_cnt;

  logic [15:0]  capture_queue [$];
  chan_result_t channel_results_due [$];
  logic [15:0]  gen_time;

  bit steady_flow;
  bit hold_request;
  bit hold_seen;
  int send_gap;
  int rx_wait;
  int rx_hold;
  int fail_count;
  int cycle_count;

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Map an interval into 0..65535 over the min/max window
  function automatic logic [15:0] scale_width(input logic [15:0] w);
    logic [15:0] span;
    logic [15:0] diff;
    logic [47:0] quo;
    if (w < min_w) return 16'h0000;
    if (w > max_w) return FULL_SCALE;
    span = max_w - min_w;
    if (span == 16'd0) return FULL_SCALE;
    diff = w - min_w;
    quo = {16'd0, diff, 16'd0} / {32'd0, span};
    return (quo > 48'(FULL_SCALE)) ? FULL_SCALE : quo[15:0];
  endfunction

  // Advance the decoder mirror by one capture and queue the channel results it releases
  function automatic void decode_capture(input logic [15:0] now);
    logic [15:0]  width;
    logic [4:0]   lim;
    int           slot;
    int           ch;
    chan_result_t r;
    chan_result_t batch [$];
    width = (now - prev_capture) << 2;
    prev_capture = now;
    if (width < MIN_INTERVAL) return;
    if (width > sep_limit) slot_idx = 5'd0;
    lim = (slot_count > MAX_SLOTS_DEF) ? 5'(MAX_SLOTS_DEF) : slot_count;
    if (slot_idx < MAX_SLOTS_DEF) interval_mem[slot_idx[3:0]] = width;
    slot_idx = slot_idx + 5'd1;
    if (slot_idx < lim) return;
    train_cnt = train_cnt + 16'd1;
    slot_idx = 5'd0;
    for (slot = odd_slots ? 1 : 2; slot < lim; slot += 2) begin
      ch = slot / 2;
      if (ch >= NUM_CHANNELS_DEF || !ch_enable[ch]) continue;
      r.channel = CH_W'(ch);
      r.position = scale_width(interval_mem[slot]);
      r.trains_seen = train_cnt;
      r.last = 1'b0;
      batch.push_back(r);
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) channel_results_due.push_back(batch[i]);
  endfunction

  // Random interval, a multiple of four within lo..hi
  function automatic logic [15:0] rand_width(input int lo, input int hi);
    int a;
    int b;
    a = (lo + 3) / 4;
    b = hi / 4;
    if (b < a) b = a;
    return 16'(4 * $urandom_range(b, a));
  endfunction

  // Clamp a channel interval into the kept range below the separation threshold
  function automatic logic [15:0] fit_width(input int w);
    int top;
    top = (sep_limit >= WIDTH_TOP) ? WIDTH_TOP : int'(sep_limit);
    if (w > top) w = top;
    if (w < KEPT_FLOOR) w = KEPT_FLOOR;
    return rand_width(w, w);
  endfunction

  task automatic push_raw(input logic [15:0] t);
    gen_time = t;
    capture_queue.push_back(t);
  endtask

  task automatic push_width(input logic [15:0] w);
    push_raw(gen_time + {2'b00, w[15:2]});
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SEPARATION:      sep_limit = val;
      CFG_SLOTS_EXPECTED:  slot_count = val[4:0];
      CFG_PULSE_AFTER_GAP: odd_slots = val[0];
      CFG_MIN_WIDTH:       min_w = val;
      CFG_MAX_WIDTH:       max_w = val;
      CFG_CHANNEL_ENABLE:  ch_enable = val[7:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [15:0] sep, input logic [4:0] slots,
                              input logic pag, input logic [15:0] lo,
                              input logic [15:0] hi, input logic [7:0] en);
    write_reg(CFG_SEPARATION, sep);
    write_reg(CFG_SLOTS_EXPECTED, {11'd0, slots});
    write_reg(CFG_PULSE_AFTER_GAP, {15'd0, pag});
    write_reg(CFG_MIN_WIDTH, lo);
    write_reg(CFG_MAX_WIDTH, hi);
    write_reg(CFG_CHANNEL_ENABLE, {8'd0, en});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every item is taken and every result is in, then let a silent walk finish
  task automatic wait_drained();
    @(negedge clk);
    while (capture_queue.size() != 0 || in_ch.valid || channel_results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Queue PPM trains fitted to the current registers, with some noise and broken trains
  task automatic queue_trains(input int trains);
    int lim;
    int n;
    int lo;
    int hi;
    int top;
    logic [15:0] w;
    top = (sep_limit >= WIDTH_TOP) ? WIDTH_TOP : int'(sep_limit);
    lo = ((min_w < max_w) ? int'(min_w) : int'(max_w)) - 256;
    hi = ((min_w < max_w) ? int'(max_w) : int'(min_w)) + 256;
    if (lo < KEPT_FLOOR) lo = KEPT_FLOOR;
    if (hi > top) hi = top;
    if (hi < lo) lo = hi;
    for (int t = 0; t < trains; t++) begin
      lim = (slot_count > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(slot_count);
      if (lim == 0) lim = 1;
      if ($urandom_range(0, 19) == 0) push_raw(16'($urandom_range(0, 65535)));
      n = lim;
      if (sep_limit < WIDTH_TOP) begin
        push_width(rand_width((sep_limit + 1 > KEPT_FLOOR) ? sep_limit + 1 : KEPT_FLOOR,
                              WIDTH_TOP));
        n = lim - 1;
      end
      if ($urandom_range(0, 5) == 0 && n > 0) n = $urandom_range(0, n - 1);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0) push_width(rand_width(0, SHORT_TOP));
        case ($urandom_range(0, 7))
          0:       w = fit_width(min_w);
          1:       w = fit_width(max_w);
          default: w = fit_width(rand_width(lo, hi));
        endcase
        push_width(w);
      end
    end
  endtask

  // Sender: offer queued captures, hold on stall, random gap after each item unless steady
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) decode_capture(in_ch.capture_time);
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (capture_queue.size() > 0) begin
          in_ch.capture_time <= capture_queue.pop_front();
          in_ch.valid <= 1'b1;
          send_gap = steady_flow ? 0 : $urandom_range(0, 15);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each taken result against the oldest one due, stall at random or on a hold request
  always @(posedge clk) begin
    chan_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
      rx_hold = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (channel_results_due.size() == 0) begin
          $error("unexpected result: channel %0d position %0d trains_seen %0d last %0b",
                 out_ch.channel, out_ch.position, out_ch.trains_seen, out_ch.last);
          fail_count++;
        end else begin
          want = channel_results_due.pop_front();
          if (out_ch.channel !== want.channel) begin
            $error("channel: expected %0d, got %0d", want.channel, out_ch.channel);
            fail_count++;
          end
          if (out_ch.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_ch.position);
            fail_count++;
          end
          if (out_ch.trains_seen !== want.trains_seen) begin
            $error("trains_seen: expected %0d, got %0d", want.trains_seen, out_ch.trains_seen);
            fail_count++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            fail_count++;
          end
        end
        rx_wait = steady_flow ? 0 : $urandom_range(0, 15);
      end
      if (hold_request != hold_seen) begin
        hold_seen = hold_request;
        rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    logic [15:0] mn;
    logic [15:0] mx;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.capture_time = '0;
    out_ch.ready = 1'b0;
    steady_flow = 1'b0;
    hold_request = 1'b0;
    hold_seen = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    gen_time = 16'd0;
    sep_limit = SEPARATION_RST;
    slot_count = SLOTS_RST;
    odd_slots = PAG_RST;
    min_w = MIN_WIDTH_RST;
    max_w = MAX_WIDTH_RST;
    ch_enable = ENABLE_RST;
    prev_capture = 16'd0;
    slot_idx = 5'd0;
    train_cnt = 16'd0;
    foreach (interval_mem[i]) interval_mem[i] = 16'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full train on even slots, window edges, short and boundary intervals
    program_regs(16'd3000, 5'd16, 1'b0, 16'd500, 16'd1500, 8'hFF);
    push_raw(16'hFFFF);
    push_width(16'd448);
    push_width(16'd452);
    push_width(16'd500);
    push_width(16'd496);
    push_width(16'd496);
    push_width(16'd1500);
    push_width(16'd1500);
    push_width(16'd1504);
    push_width(16'd1504);
    push_width(16'd1000);
    push_width(16'd1000);
    push_width(16'd504);
    push_width(16'd504);
    push_width(16'd1496);
    push_width(16'd1496);
    push_width(16'd2996);
    push_raw(16'h0000);
    wait_drained();

    // Directed: equal window on odd slots
    program_regs(16'd2000, 5'd6, 1'b1, 16'd1000, 16'd1000, 8'hFF);
    push_width(16'd2400);
    push_width(16'd1000);
    push_width(16'd996);
    push_width(16'd996);
    push_width(16'd1004);
    push_width(16'd1004);
    wait_drained();

    // Plain trains at a typical setting
    program_regs(16'd3000, 5'd16, 1'b0, 16'd1000, 16'd2000, 8'hFF);
    queue_trains(2);
    wait_drained();

    // No train gap possible, oversized slot count, full-range window
    program_regs(16'hFFFF, 5'd31, 1'b1, 16'd0, 16'hFFFF, 8'hFF);
    queue_trains(1);
    wait_drained();

    // Inverted window
    program_regs(16'd3000, 5'd12, 1'b1, 16'd1600, 16'd900, 8'hAA);
    queue_trains(2);
    wait_drained();

    // Zero slot count and zero separation: every kept capture closes a silent train
    program_regs(16'd0, 5'd0, 1'b0, 16'hFFFF, 16'd0, 8'h00);
    for (int i = 0; i < 8; i++) push_raw(16'($urandom_range(0, 65535)));
    wait_drained();

    // Receiver holds off while the sender streams trains without gaps
    program_regs(16'd3000, 5'd16, 1'b0, 16'd500, 16'd1500, 8'hFF);
    steady_flow = 1'b1;
    hold_request = ~hold_request;
    queue_trains(3);
    wait_drained();
    steady_flow = 1'b0;

    // Random settings
    for (int p = 0; p < 5; p++) begin
      mn = 16'($urandom_range(452, 2000));
      mx = mn + 16'($urandom_range(0, 2000));
      program_regs(16'($urandom_range(2500, 8000)), 5'($urandom_range(1, 16)),
                   1'($urandom_range(0, 1)), mn, mx, 8'($urandom));
      steady_flow = (p == 2);
      queue_trains(1);
      wait_drained();
    end
    steady_flow = 1'b0;

    if (fail_count == 0 && channel_results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ppmd_pkg.sv
design/ppmd_if.sv
design/ppmd_cfg_regs.sv
design/ppmd_scaler.sv
design/ppm_pulse_train_decoder.sv
tb/tb_ppm_pulse_train_decoder.sv
